// ----- rtl/amgs_pkg.sv -----
// ----------------------------------------------------------------------------
// amgs_pkg
// Shared types and codes for the adjacency matrix graph store.
// ----------------------------------------------------------------------------
package amgs_pkg;

	localparam int REQ_W = 3;
	localparam int VTX_W = 4;
	localparam int WT_W  = 16;
	localparam int CNT_W = 5;

	typedef enum logic [REQ_W-1:0] {
		REQ_ADD_VERTEX = 3'd0,
		REQ_REM_VERTEX = 3'd1,
		REQ_ADD_EDGE   = 3'd2,
		REQ_REM_EDGE   = 3'd3,
		REQ_READ_EDGE  = 3'd4
	} req_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_MIRROR,
		ST_SWEEP_ROW,
		ST_SWEEP_COL
	} state_t;

endpackage

// ----- rtl/adjacency_matrix_graph_store.sv -----
// ----------------------------------------------------------------------------
// adjacency_matrix_graph_store
// Weighted adjacency matrix in one synchronous RAM, with per-vertex used bits
// and a vertex count; add/remove vertex, add/remove/read edge requests.
// ----------------------------------------------------------------------------
// Results are registered and shown in the cycle after accept, except read edge's,
// which pass the RAM read register and ST_READ first. Read edge, mirrored edge
// writes and add vertex leave idle for ST_READ, ST_MIRROR or ST_SWEEP_ROW/COL;
// the sweep clears the new vertex's row and column through the single RAM write port.
// Reset: arst_n clears used bits, count, mode and control; the matrix RAM is not
// reset, a vertex's row and column are zeroed when it is added.
module adjacency_matrix_graph_store #(
	parameter int MAX_VERTICES = 16,
	parameter int WEIGHT_BITS  = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_wdata,     // directed_mode
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,       // vertex_a[3:0], vertex_b[7:4], edge_weight[23:8]
	input  logic [2:0]  s_tuser,       // req_type[2:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,       // weight_read[15:0], vertex_total[20:16], zero fill
	output logic        m_tuser        // ok
);

	localparam int VW    = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
	localparam int DEPTH = 1 << (2 * VW);

	// matrix ram
	logic [WEIGHT_BITS-1:0] mem [DEPTH];
	logic                   mem_we;
	logic [2*VW-1:0]        mem_waddr;
	logic [WEIGHT_BITS-1:0] mem_wdata;
	logic [WEIGHT_BITS-1:0] rd_data_q;

	amgs_pkg::state_t state_q, state_d;

	logic                          directed_q;
	logic [MAX_VERTICES-1:0]       used_q, used_d;
	logic [amgs_pkg::CNT_W-1:0]    count_q, count_d;
	logic [VW-1:0]                 op_a_q, op_b_q, sw_q;
	logic [WEIGHT_BITS-1:0]        op_w_q;
	logic                          read_ok_q;

	logic                          out_valid_q;
	logic                          out_ok_q;
	logic [amgs_pkg::WT_W-1:0]     out_weight_q;
	logic [amgs_pkg::CNT_W-1:0]    out_total_q;

	// input fields
	logic [amgs_pkg::REQ_W-1:0]    in_req;
	logic [amgs_pkg::VTX_W-1:0]    in_a, in_b;
	logic [amgs_pkg::WT_W-1:0]     in_w;
	logic [VW-1:0]                 idx_a, idx_b;
	logic                          a_in_range, b_in_range, used_a, used_b;
	logic                          accept;
	logic                          sweep_last;

	// result of the accepted request
	logic                          ok_c;
	logic                          load_out;
	logic                          out_ok_c;
	logic [amgs_pkg::WT_W-1:0]     out_weight_c;

	assign in_req = s_tuser;
	assign in_a   = s_tdata[3:0];
	assign in_b   = s_tdata[7:4];
	assign in_w   = s_tdata[23:8];
	assign idx_a  = VW'(in_a);
	assign idx_b  = VW'(in_b);

	assign a_in_range = 32'(in_a) < MAX_VERTICES;
	assign b_in_range = 32'(in_b) < MAX_VERTICES;
	assign used_a     = a_in_range && used_q[idx_a];
	assign used_b     = b_in_range && used_q[idx_b];

	assign s_tready   = (state_q == amgs_pkg::ST_IDLE) && (!out_valid_q || m_tready);
	assign accept     = s_tvalid && s_tready;
	assign sweep_last = sw_q == VW'(MAX_VERTICES - 1);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			amgs_pkg::ST_IDLE: begin
				if (accept) begin
					case (in_req)
						amgs_pkg::REQ_ADD_VERTEX: begin
							if (ok_c)
								state_d = amgs_pkg::ST_SWEEP_ROW;
						end
						amgs_pkg::REQ_ADD_EDGE, amgs_pkg::REQ_REM_EDGE: begin
							if (ok_c && !directed_q)
								state_d = amgs_pkg::ST_MIRROR;
						end
						amgs_pkg::REQ_READ_EDGE: state_d = amgs_pkg::ST_READ;
						default: state_d = amgs_pkg::ST_IDLE;
					endcase
				end
			end
			amgs_pkg::ST_READ:   state_d = amgs_pkg::ST_IDLE;
			amgs_pkg::ST_MIRROR: state_d = amgs_pkg::ST_IDLE;
			amgs_pkg::ST_SWEEP_ROW: begin
				if (sweep_last)
					state_d = amgs_pkg::ST_SWEEP_COL;
			end
			amgs_pkg::ST_SWEEP_COL: begin
				if (sweep_last)
					state_d = amgs_pkg::ST_IDLE;
			end
			default: state_d = amgs_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		ok_c         = 1'b0;
		used_d       = used_q;
		count_d      = count_q;
		mem_we       = 1'b0;
		mem_waddr    = {idx_a, idx_b};
		mem_wdata    = WEIGHT_BITS'(in_w);
		load_out     = 1'b0;
		out_ok_c     = 1'b0;
		out_weight_c = '0;
		unique case (state_q)
			amgs_pkg::ST_IDLE: begin
				case (in_req)
					amgs_pkg::REQ_ADD_VERTEX: ok_c = a_in_range && !used_q[idx_a];
					amgs_pkg::REQ_REM_VERTEX: ok_c = used_a;
					amgs_pkg::REQ_ADD_EDGE, amgs_pkg::REQ_REM_EDGE,
					amgs_pkg::REQ_READ_EDGE: ok_c = used_a && used_b;
					default: ok_c = 1'b0;
				endcase
				if (in_req == amgs_pkg::REQ_REM_EDGE)
					mem_wdata = '0;
				if (accept) begin
					load_out = in_req != amgs_pkg::REQ_READ_EDGE;
					out_ok_c = ok_c;
					if (ok_c) begin
						case (in_req)
							amgs_pkg::REQ_ADD_VERTEX: begin
								used_d[idx_a] = 1'b1;
								count_d       = count_q + 1'b1;
							end
							amgs_pkg::REQ_REM_VERTEX: begin
								used_d[idx_a] = 1'b0;
								count_d       = count_q - 1'b1;
							end
							amgs_pkg::REQ_ADD_EDGE, amgs_pkg::REQ_REM_EDGE: mem_we = 1'b1;
							default: mem_we = 1'b0;
						endcase
					end
				end
			end
			amgs_pkg::ST_READ: begin
				// entries touching an unused vertex read as zero
				load_out     = 1'b1;
				out_ok_c     = read_ok_q;
				out_weight_c = read_ok_q ? amgs_pkg::WT_W'(rd_data_q) : '0;
			end
			amgs_pkg::ST_MIRROR: begin
				mem_we    = 1'b1;
				mem_waddr = {op_b_q, op_a_q};
				mem_wdata = op_w_q;
			end
			amgs_pkg::ST_SWEEP_ROW: begin
				mem_we    = 1'b1;
				mem_waddr = {op_a_q, sw_q};
				mem_wdata = '0;
			end
			amgs_pkg::ST_SWEEP_COL: begin
				mem_we    = 1'b1;
				mem_waddr = {sw_q, op_a_q};
				mem_wdata = '0;
			end
			default: mem_we = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= amgs_pkg::ST_IDLE;
			directed_q  <= 1'b0;
			used_q      <= '0;
			count_q     <= '0;
			sw_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			used_q  <= used_d;
			count_q <= count_d;
			if (cfg_we)
				directed_q <= cfg_wdata;
			if (state_q == amgs_pkg::ST_SWEEP_ROW || state_q == amgs_pkg::ST_SWEEP_COL)
				sw_q <= sweep_last ? '0 : sw_q + 1'b1;
			if (load_out)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
		end
	end

	// request operands and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			op_a_q    <= idx_a;
			op_b_q    <= idx_b;
			op_w_q    <= mem_wdata;
			read_ok_q <= ok_c;
		end
		if (load_out) begin
			out_ok_q     <= out_ok_c;
			out_weight_q <= out_weight_c;
			out_total_q  <= count_d;
		end
	end

	// ram ports; the RAM is read at every accept, an edge write also lands there, and any
	// follow-up writes finish before the next request is taken
	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_waddr] <= mem_wdata;
	end

	always_ff @(posedge clk) begin
		if (accept)
			rd_data_q <= mem[{idx_a, idx_b}];
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_ok_q;
	assign m_tdata  = {3'b000, out_total_q, out_weight_q};

	a_count_matches_used: assert property (@(posedge clk) disable iff (!arst_n)
		32'(count_q) == $countones(used_q))
		else $error("vertex count differs from number of used bits");

	a_add_starts_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		accept && in_req == amgs_pkg::REQ_ADD_VERTEX && ok_c
		|=> state_q == amgs_pkg::ST_SWEEP_ROW && sw_q == '0)
		else $error("accepted vertex add did not start row clear");

	a_read_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == amgs_pkg::ST_READ |=> m_tvalid)
		else $error("edge read produced no result");

	a_no_accept_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we && state_q != amgs_pkg::ST_IDLE |-> !s_tready)
		else $error("request taken during a ram write sequence");

	a_total_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> 32'(out_total_q) <= MAX_VERTICES)
		else $error("vertex total above capacity");

endmodule
